// ===== design/rlpm_pkg.sv =====
`default_nettype none

package rlpm_pkg;

  // command codes of an input item
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // result status codes
  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_HIT     = 3'd2;
  localparam logic [2:0] ST_MISS    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  // stored route word: masked destination, mask, gateway, interface, prefix
  localparam int ENTRY_W = 32 + 32 + 32 + 4 + 6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] route_dest;
    logic [31:0] route_mask;
    logic [31:0] route_gateway;
    logic [3:0]  route_iface;
    logic [31:0] lookup_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] hop_addr;
    logic [3:0]  hop_iface;
    logic [5:0]  match_len;
    logic [4:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] dest_masked;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [3:0]  iface;
    logic [5:0]  prefix;
  } route_entry_t;

  // controller to datapath
  typedef struct packed {
    logic cap;         // capture the accepted item
    logic clr;         // empty the table
    logic full_ack;    // add refused, table at capacity
    logic lo_start;    // begin leading-ones count of the mask
    logic lo_step;     // count one more mask byte
    logic wr;          // write the new route and bump the count
    logic scan_start;  // reset the best-match tracking
    logic scan_issue;  // read the next table entry
    logic load;        // build the result into the output register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       lo_last;
    logic       scan_last;
  } dp_sts_t;

  // controller states
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_LONES  = 7'b0000100,
    S_WRITE  = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_FINISH = 7'b1000000
  } ctl_state_t;

  // leading ones of one mask byte, msb first
  function automatic logic [3:0] byte_lones(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int k = 7; k >= 0; k--) begin
      run = run & b[k];
      n   = n + {3'd0, run};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== design/rlpm_ram.sv =====
`default_nettype none

module rlpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/rlpm_dp.sv =====
`default_nettype none

module rlpm_dp #(
  parameter int ROUTES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rlpm_pkg::in_item_t  in_item,
  input  wire rlpm_pkg::ctl_cmd_t  cmd,
  output rlpm_pkg::dp_sts_t        sts,
  output rlpm_pkg::out_item_t      out_item
);

  import rlpm_pkg::*;

  localparam int IW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
  localparam int CW = $clog2(ROUTES + 1);

  in_item_t     item_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [5:0]   lones_r, lones_nxt;
  logic [31:0]  lo_sh_r, lo_sh_nxt;
  logic [1:0]   lo_k_r, lo_k_nxt;
  logic         lo_run_r, lo_run_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic         cmp_valid_r, cmp_valid_nxt;
  logic         found_r, found_nxt;
  logic [5:0]   best_len_r, best_len_nxt;
  logic [31:0]  best_gw_r, best_gw_nxt;
  logic [3:0]   best_if_r, best_if_nxt;
  logic [2:0]   status_r, status_nxt;
  out_item_t    out_r, out_nxt;

  route_entry_t wr_entry;
  route_entry_t rd_entry;
  logic [ENTRY_W-1:0] rd_word;
  logic [3:0]   byte_n;
  logic         match;
  logic [CW+4:0] cnt_ext;

  // route table storage
  assign wr_entry.dest_masked = item_r.route_dest & item_r.route_mask;
  assign wr_entry.mask        = item_r.route_mask;
  assign wr_entry.gateway     = item_r.route_gateway;
  assign wr_entry.iface       = item_r.route_iface;
  assign wr_entry.prefix      = lones_r;

  rlpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ROUTES)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.wr),
    .wr_addr (count_r[IW-1:0]),
    .wr_data (wr_entry),
    .rd_en   (cmd.scan_issue),
    .rd_addr (rd_idx_r),
    .rd_data (rd_word)
  );

  assign rd_entry = route_entry_t'(rd_word);

  // status back to the controller
  assign sts.op        = item_r.cmd;
  assign sts.full      = (count_r == CW'(ROUTES));
  assign sts.empty     = (count_r == '0);
  assign sts.lo_last   = (lo_k_r == 2'd3);
  assign sts.scan_last = ({1'b0, rd_idx_r} == (IW + 1)'(count_r - CW'(1)));

  assign byte_n  = byte_lones(lo_sh_r[31:24]);
  assign match   = ((item_r.lookup_addr & rd_entry.mask) == rd_entry.dest_masked);
  assign cnt_ext = {5'd0, count_r};

  // next-state logic
  always_comb begin
    count_nxt     = count_r;
    lones_nxt     = lones_r;
    lo_sh_nxt     = lo_sh_r;
    lo_k_nxt      = lo_k_r;
    lo_run_nxt    = lo_run_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_valid_nxt = cmd.scan_issue;
    found_nxt     = found_r;
    best_len_nxt  = best_len_r;
    best_gw_nxt   = best_gw_r;
    best_if_nxt   = best_if_r;
    status_nxt    = status_r;
    out_nxt       = out_r;

    if (cmd.clr) begin
      count_nxt  = '0;
      status_nxt = ST_CLEARED;
    end
    if (cmd.full_ack) begin
      status_nxt = ST_FULL;
    end

    // leading-ones count, one mask byte per step
    if (cmd.lo_start) begin
      lones_nxt  = 6'd0;
      lo_sh_nxt  = item_r.route_mask;
      lo_k_nxt   = 2'd0;
      lo_run_nxt = 1'b1;
    end
    if (cmd.lo_step) begin
      if (lo_run_r) begin
        lones_nxt = lones_r + {2'd0, byte_n};
      end
      lo_run_nxt = lo_run_r & (byte_n == 4'd8);
      lo_sh_nxt  = lo_sh_r << 8;
      lo_k_nxt   = lo_k_r + 2'd1;
    end

    // append the route
    if (cmd.wr) begin
      count_nxt  = count_r + CW'(1);
      status_nxt = ST_ADDED;
    end

    // scan, one entry per cycle; ties keep the earlier entry
    if (cmd.scan_start) begin
      rd_idx_nxt = '0;
      found_nxt  = 1'b0;
      status_nxt = ST_MISS;
    end
    if (cmd.scan_issue) begin
      rd_idx_nxt = rd_idx_r + IW'(1);
    end
    if (cmp_valid_r && match && (!found_r || (rd_entry.prefix > best_len_r))) begin
      found_nxt    = 1'b1;
      best_len_nxt = rd_entry.prefix;
      best_gw_nxt  = rd_entry.gateway;
      best_if_nxt  = rd_entry.iface;
      status_nxt   = ST_HIT;
    end

    // result
    if (cmd.load) begin
      out_nxt.status      = status_r;
      out_nxt.hop_addr    = 32'd0;
      out_nxt.hop_iface   = 4'd0;
      out_nxt.match_len   = 6'd0;
      out_nxt.entry_count = cnt_ext[4:0];
      if (status_r == ST_HIT) begin
        out_nxt.hop_addr  = (best_gw_r == 32'd0) ? item_r.lookup_addr : best_gw_r;
        out_nxt.hop_iface = best_if_r;
        out_nxt.match_len = best_len_r;
      end else if (status_r == ST_ADDED) begin
        out_nxt.match_len = lones_r;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      item_r <= in_item;
    end
    lones_r    <= lones_nxt;
    lo_sh_r    <= lo_sh_nxt;
    lo_k_r     <= lo_k_nxt;
    lo_run_r   <= lo_run_nxt;
    rd_idx_r   <= rd_idx_nxt;
    found_r    <= found_nxt;
    best_len_r <= best_len_nxt;
    best_gw_r  <= best_gw_nxt;
    best_if_r  <= best_if_nxt;
    status_r   <= status_nxt;
    out_r      <= out_nxt;
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

// ===== design/rlpm_ctrl.sv =====
`default_nettype none

module rlpm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire rlpm_pkg::dp_sts_t  sts,
  output rlpm_pkg::ctl_cmd_t      cmd
);

  import rlpm_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // sequencing of one item
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.op == OP_CLEAR) begin
          cmd.clr   = 1'b1;
          state_nxt = S_FINISH;
        end else if (sts.op == OP_ADD) begin
          if (sts.full) begin
            cmd.full_ack = 1'b1;
            state_nxt    = S_FINISH;
          end else begin
            cmd.lo_start = 1'b1;
            state_nxt    = S_LONES;
          end
        end else begin
          // lookup, also for the unused code
          cmd.scan_start = 1'b1;
          state_nxt      = sts.empty ? S_FINISH : S_SCAN;
        end
      end
      S_LONES: begin
        cmd.lo_step = 1'b1;
        if (sts.lo_last) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr    = 1'b1;
        state_nxt = S_FINISH;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid: set on load, cleared when the item is taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/route_longest_prefix_match_core.sv =====
`default_nettype none

// channel   direction  ports
// input     in         in_valid, in_stall, in_item
// result    out        out_valid, out_stall, out_item
//
// clear, a refused add and a lookup of an empty table go from decode straight to the result load.
// add counts the mask prefix one byte per cycle, then writes the route and loads its result.
// lookup reads the N stored routes, one table read per cycle, then loads its result.
// the input opens in the cycle after the load, so an item is taken only once the one before has loaded.
// a held result only delays the next load; a new item is taken while it waits.
// reset empties the table; route storage itself is not cleared.
module route_longest_prefix_match_core #(
  parameter int ROUTES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rlpm_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rlpm_pkg::out_item_t      out_item
);

  import rlpm_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencer
  rlpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table and match logic
  rlpm_dp #(
    .ROUTES (ROUTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// ===== tb/route_longest_prefix_match_core_test.sv =====
`default_nettype none

module route_longest_prefix_match_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rlpm_pkg::*;

  localparam int ROUTES       = 16;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_WAIT   = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 800;

  // spare command code, the block treats it as a lookup
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    in_item_t item;
    bit       drain_first;
  } pend_t;

  typedef struct {
    logic [31:0] dest;
    logic [31:0] mask;
  } gen_route_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  route_longest_prefix_match_core #(.ROUTES(ROUTES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // shadow route table
  logic [31:0]       tbl_dest [ROUTES];
  logic [31:0]       tbl_mask [ROUTES];
  logic [31:0]       tbl_gw   [ROUTES];
  logic [3:0]        tbl_iface[ROUTES];
  logic [5:0]        tbl_len  [ROUTES];
  logic [ROUTES-1:0] tbl_valid = '0;
  int                tbl_count = 0;

  pend_t      pend_q[$];
  out_item_t  due_q[$];
  gen_route_t gen_routes[$];

  int sent_cnt    = 0;
  int done_cnt    = 0;
  int err_cnt     = 0;
  int cycles      = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int fill_stalls = 0;
  int n_added = 0, n_full = 0, n_hit = 0, n_miss = 0, n_clear = 0;
  logic quiet;

  // no random idling on either side over this stretch
  assign quiet = (sent_cnt >= 300) && (sent_cnt < 600);

  function automatic logic [5:0] mask_lead_ones(logic [31:0] m);
    logic [5:0] n;
    n = '0;
    for (int b = 31; b >= 0 && m[b]; b--) n++;
    return n;
  endfunction

  function automatic logic [31:0] mask_of(int n);
    return (n == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - n);
  endfunction

  // next-hop result of one item, updates the shadow table
  function automatic out_item_t route_predict(in_item_t it);
    out_item_t r;
    int        best;
    bit        found;
    r     = '0;
    best  = 0;
    found = 1'b0;
    case (it.cmd)
      OP_CLEAR: begin
        tbl_valid = '0;
        tbl_count = 0;
        r.status  = ST_CLEARED;
      end
      OP_ADD: begin
        if (tbl_count >= ROUTES) begin
          r.status = ST_FULL;
        end else begin
          tbl_dest[tbl_count]  = it.route_dest;
          tbl_mask[tbl_count]  = it.route_mask;
          tbl_gw[tbl_count]    = it.route_gateway;
          tbl_iface[tbl_count] = it.route_iface;
          tbl_len[tbl_count]   = mask_lead_ones(it.route_mask);
          tbl_valid[tbl_count] = 1'b1;
          r.match_len          = tbl_len[tbl_count];
          r.status             = ST_ADDED;
          tbl_count++;
        end
      end
      default: begin
        // longest prefix wins, strict compare keeps the earliest on a tie
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_valid[i] &&
              ((it.lookup_addr & tbl_mask[i]) == (tbl_dest[i] & tbl_mask[i])) &&
              (!found || tbl_len[i] > tbl_len[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (found) begin
          r.status    = ST_HIT;
          r.hop_addr  = (tbl_gw[best] == 32'h0) ? it.lookup_addr : tbl_gw[best];
          r.hop_iface = tbl_iface[best];
          r.match_len = tbl_len[best];
        end else begin
          r.status = ST_MISS;
        end
      end
    endcase
    r.entry_count = 5'(tbl_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_cnt++;
    if (err_cnt <= 30)
      $display("mismatch %s at result %0d: got %h want %h", what, done_cnt, got, want);
  endtask

  // stimulus queue, also tracks stored routes so lookups can aim at them
  task automatic queue_item(logic [1:0] cmd, logic [31:0] dest, logic [31:0] mask,
                            logic [31:0] gw, logic [3:0] ifc, logic [31:0] addr,
                            bit drain);
    pend_t      p;
    gen_route_t g;
    p.item.cmd           = cmd;
    p.item.route_dest    = dest;
    p.item.route_mask    = mask;
    p.item.route_gateway = gw;
    p.item.route_iface   = ifc;
    p.item.lookup_addr   = addr;
    p.drain_first        = drain;
    pend_q.push_back(p);
    if (cmd == OP_CLEAR) begin
      gen_routes.delete();
    end else if (cmd == OP_ADD && gen_routes.size() < ROUTES) begin
      g.dest = dest;
      g.mask = mask;
      gen_routes.push_back(g);
    end
  endtask

  task automatic queue_add(logic [31:0] dest, logic [31:0] mask);
    queue_item(OP_ADD, dest, mask, ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom,
               4'($urandom_range(0, 15)), $urandom, 1'b0);
  endtask

  function automatic logic [31:0] pick_mask();
    int k;
    k = $urandom_range(0, 99);
    if (k < 80) return mask_of($urandom_range(0, 32));
    if (k < 90) return $urandom;
    return mask_of($urandom_range(8, 32)) ^ (32'h1 << $urandom_range(0, 31));
  endfunction

  task automatic build_directed();
    // empty table, then default route, host route, odd mask and a tie
    queue_item(OP_CLEAR, '0, '0, '0, '0, '0, 1'b0);
    queue_item(OP_LOOKUP, '1, '1, '1, '1, 32'hFFFF_FFFF, 1'b0);
    queue_item(OP_ADD, 32'h0, 32'h0, 32'h0, 4'h0, '1, 1'b0);
    queue_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, '0, 1'b0);
    queue_item(OP_ADD, 32'hC0A8_0001, 32'hFF00_FF00, 32'h0A00_0001, 4'h5, '0, 1'b0);
    queue_item(OP_ADD, 32'hC0A8_0001, 32'hFF00_FF00, 32'h0A00_0002, 4'h6, '0, 1'b0);
    queue_item(OP_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFF, 1'b0);
    queue_item(OP_SPARE, '1, '1, '1, '1, 32'h0, 1'b0);
    queue_item(OP_LOOKUP, '0, '0, '0, '0, 32'hC011_0022, 1'b0);
    queue_item(OP_LOOKUP, '0, '0, '0, '0, 32'h1234_5678, 1'b0);
    // fill to capacity, then one add too many
    for (int k = 0; k < ROUTES - 4; k++)
      queue_add(32'h0A00_0000 + (k << 8), mask_of(24 + k % 9));
    queue_item(OP_ADD, 32'h0B00_0000, 32'hFF00_0000, 32'h1, 4'h1, '0, 1'b0);
    queue_item(OP_LOOKUP, '0, '0, '0, '0, 32'h0A00_0305, 1'b0);
    queue_item(OP_CLEAR, '1, '1, '1, '1, '1, 1'b1);
    queue_item(OP_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic build_random();
    int          n_items;
    int          n_add;
    int          n_look;
    int          k2;
    bit          first;
    logic [31:0] base[4];
    logic [31:0] d;
    logic [31:0] m;
    logic [31:0] a;
    gen_route_t  r;
    n_items = 0;
    first   = 1'b1;
    d       = '0;
    m       = '0;
    while (n_items < RANDOM_ITEMS) begin
      foreach (base[j]) base[j] = $urandom;
      // most sequences start from an empty table
      if (first || $urandom_range(0, 9) < 8) begin
        queue_item(OP_CLEAR, $urandom, $urandom, $urandom, 4'($urandom_range(0, 15)),
                   $urandom, first || $urandom_range(0, 29) == 0);
        n_items++;
      end
      first = 1'b0;
      n_add = $urandom_range(0, 18);
      for (int k = 0; k < n_add; k++) begin
        // sometimes repeat the previous prefix to force a tie
        if (k == 0 || $urandom_range(0, 5) != 0) begin
          d = base[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(0, 31));
          m = pick_mask();
        end
        queue_add(d, m);
        n_items++;
      end
      n_look = $urandom_range(4, 30);
      for (int k = 0; k < n_look; k++) begin
        k2 = $urandom_range(0, 99);
        if (k2 < 8) begin
          queue_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                     4'($urandom_range(0, 15)), $urandom, 1'b0);
        end else begin
          if (gen_routes.size() > 0 && k2 < 75) begin
            r = gen_routes[$urandom_range(0, gen_routes.size() - 1)];
            a = (r.dest & r.mask) | ($urandom & ~r.mask);
          end else if (k2 < 85) begin
            a = base[$urandom_range(0, 3)];
          end else begin
            a = $urandom;
          end
          queue_item((k2 % 10 == 0) ? OP_SPARE : OP_LOOKUP, $urandom, $urandom, $urandom,
                     4'($urandom_range(0, 15)), a, 1'b0);
        end
        n_items++;
      end
    end
  endtask

  // driver: offers queued items, may wait for the block to drain first
  always @(posedge clk) begin
    int    owed;
    bit    send;
    pend_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      owed = sent_cnt - done_cnt;
      if (in_valid && !in_stall) begin
        due_q.push_back(route_predict(in_item));
        sent_cnt <= sent_cnt + 1;
        owed++;
      end
      if (!(in_valid && in_stall)) begin
        send = pend_q.size() > 0;
        if (send && pend_q[0].drain_first && owed != 0) send = 1'b0;
        if (send && !quiet && $urandom_range(0, 99) < 10) send = 1'b0;
        if (send) begin
          p = pend_q.pop_front();
          in_item <= p.item;
        end
        in_valid <= send;
      end
    end
  end

  // hold-off length counter, one long stretch once enough results are in
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && done_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // monitor: checks each result item, drives the result stall
  always @(posedge clk) begin
    out_item_t want;
    bit        stall;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (done_cnt >= sent_cnt) begin
          report_mismatch("result with none expected", 32'(out_item.status), 32'h0);
        end else begin
          want = due_q.pop_front();
          done_cnt <= done_cnt + 1;
          if (out_item.status !== want.status)
            report_mismatch("status", 32'(out_item.status), 32'(want.status));
          if (out_item.hop_addr !== want.hop_addr)
            report_mismatch("hop_addr", out_item.hop_addr, want.hop_addr);
          if (out_item.hop_iface !== want.hop_iface)
            report_mismatch("hop_iface", 32'(out_item.hop_iface), 32'(want.hop_iface));
          if (out_item.match_len !== want.match_len)
            report_mismatch("match_len", 32'(out_item.match_len), 32'(want.match_len));
          if (out_item.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(out_item.entry_count),
                            32'(want.entry_count));
          case (want.status)
            ST_ADDED: n_added++;
            ST_FULL:  n_full++;
            ST_HIT:   n_hit++;
            ST_MISS:  n_miss++;
            default:  n_clear++;
          endcase
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left > 0) begin
        stall = 1'b1;
        if (in_valid && in_stall) fill_stalls++;
      end else if (!hold_done && done_cnt >= HOLD_AT) begin
        stall = 1'b1;
      end else begin
        stall = !quiet && $urandom_range(0, 99) < 10;
      end
      out_stall <= stall;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items sent, %0d results", cycles, sent_cnt,
               done_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    build_directed();
    build_random();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (pend_q.size() != 0 || in_valid) @(posedge clk);
    while (done_cnt != sent_cnt) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (due_q.size() != 0)
      report_mismatch("results never arrived", 32'(due_q.size()), 32'h0);
    $display("%0d items checked: %0d adds, %0d refused adds, %0d hits, %0d misses, %0d clears",
             done_cnt, n_added, n_full, n_hit, n_miss, n_clear);
    $display("input backed up for %0d cycles during the output hold-off, %0d errors",
             fill_stalls, err_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/rlpm_pkg.sv
design/rlpm_ram.sv
design/rlpm_dp.sv
design/rlpm_ctrl.sv
design/route_longest_prefix_match_core.sv
tb/route_longest_prefix_match_core_test.sv
